>>> design/hkms_pkg.sv
`default_nettype none
package hkms_pkg;
    localparam int BUCKETS = 256;
    localparam int WAYS = 4;
    localparam int BKT_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int CNT_W = $clog2(BUCKETS + 1);
    localparam int ROW_W = WAYS * 33;
    localparam int KEY_W = 32;
    localparam int DIV_CNT_W = 6;

    typedef enum logic [1:0] {
        CMD_CONTAINS = 2'd0,
        CMD_ADD      = 2'd1,
        CMD_DELETE   = 2'd2,
        CMD_SPARE    = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIVIDE,
        ST_READ,
        ST_UPDATE,
        ST_OUTPUT
    } state_t;

    typedef struct packed {
        logic clear_step;
        logic load;
        logic div_step;
        logic read_row;
        logic update;
    } ctrl_t;

    typedef struct packed {
        logic clear_done;
        logic div_done;
    } stat_t;
endpackage
`default_nettype wire

>>> design/hkms_if.sv
`default_nettype none
interface hkms_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [31:0] key_hash;
    modport source (output valid, cmd, key_hash, input ready);
    modport sink (input valid, cmd, key_hash, output ready);
endinterface

interface hkms_rsp_if;
    logic valid;
    logic ready;
    logic found;
    logic status;
    modport source (output valid, found, status, input ready);
    modport sink (input valid, found, status, output ready);
endinterface
`default_nettype wire

>>> design/hkms_ram.sv
`default_nettype none
module hkms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

>>> design/hkms_ctrl.sv
`default_nettype none
module hkms_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    output logic                 req_ready,
    output logic                 rsp_valid,
    input  wire logic            rsp_ready,
    input  wire hkms_pkg::stat_t stat,
    output hkms_pkg::ctrl_t      ctrl
);
    hkms_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hkms_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl = '0;
        req_ready = 1'b0;
        rsp_valid = 1'b0;
        case (state_reg)
            hkms_pkg::ST_CLEAR:
            begin
                ctrl.clear_step = 1'b1;
                if (stat.clear_done)
                begin
                    state_next = hkms_pkg::ST_IDLE;
                end
            end
            hkms_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    ctrl.load = 1'b1;
                    state_next = hkms_pkg::ST_DIVIDE;
                end
            end
            hkms_pkg::ST_DIVIDE:
            begin
                ctrl.div_step = 1'b1;
                if (stat.div_done)
                begin
                    state_next = hkms_pkg::ST_READ;
                end
            end
            hkms_pkg::ST_READ:
            begin
                ctrl.read_row = 1'b1;
                state_next = hkms_pkg::ST_UPDATE;
            end
            hkms_pkg::ST_UPDATE:
            begin
                ctrl.update = 1'b1;
                state_next = hkms_pkg::ST_OUTPUT;
            end
            hkms_pkg::ST_OUTPUT:
            begin
                rsp_valid = 1'b1;
                if (rsp_ready)
                begin
                    state_next = hkms_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hkms_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(req_ready && rsp_valid)) else $error("ready while response pending");
    a_div_leaves: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hkms_pkg::ST_READ) |=> (state_reg == hkms_pkg::ST_UPDATE))
        else $error("read not followed by update");
    a_accept_divides: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> (state_reg == hkms_pkg::ST_DIVIDE))
        else $error("accept did not start divide");
`endif
endmodule
`default_nettype wire

>>> design/hkms_dp.sv
`default_nettype none
module hkms_dp (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire hkms_pkg::ctrl_t ctrl,
    output hkms_pkg::stat_t      stat,
    input  wire logic [1:0]      cmd,
    input  wire logic [31:0]     key_hash,
    input  wire logic [8:0]      nbkt,
    output logic                 found,
    output logic                 status
);
    localparam int BW = hkms_pkg::BKT_W;
    localparam int CW = hkms_pkg::CNT_W;
    localparam int W = hkms_pkg::WAYS;
    localparam int DW = hkms_pkg::DIV_CNT_W;

    logic [1:0]  cmd_reg;
    logic [31:0] key_reg;
    logic [31:0] quo_reg;
    logic [CW-1:0] rem_reg;
    logic [CW-1:0] div_reg;
    logic [DW-1:0] cnt_reg;
    logic [BW-1:0] clr_reg;
    logic          found_reg, status_reg;
    logic [CW:0]   trial;
    logic [CW-1:0] eff;
    logic [hkms_pkg::ROW_W-1:0] row_rd, row_wr;
    logic          row_we;
    logic [BW-1:0] waddr;
    logic          hit, have_free;
    logic [W-1:0]  hit_oh, free_oh;

    // clamp the bucket count into 1..BUCKETS
    always_comb
    begin
        if (nbkt == '0)
        begin
            eff = CW'(1);
        end
        else if (32'(nbkt) > 32'(hkms_pkg::BUCKETS))
        begin
            eff = CW'(hkms_pkg::BUCKETS);
        end
        else
        begin
            eff = CW'(nbkt);
        end
    end

    assign trial = {rem_reg, quo_reg[31]} - {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (ctrl.clear_step)
            begin
                clr_reg <= clr_reg + BW'(1);
            end
            if (ctrl.load)
            begin
                cnt_reg <= '0;
            end
            else if (ctrl.div_step)
            begin
                cnt_reg <= cnt_reg + DW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg <= cmd;
            key_reg <= key_hash;
            quo_reg <= key_hash;
            rem_reg <= '0;
            div_reg <= eff;
        end
        else if (ctrl.div_step)
        begin
            // one restoring step per cycle; quotient bits unused
            quo_reg <= {quo_reg[30:0], 1'b0};
            if (!trial[CW])
            begin
                rem_reg <= trial[CW-1:0];
            end
            else
            begin
                rem_reg <= {rem_reg[CW-2:0], quo_reg[31]};
            end
        end
        if (ctrl.update)
        begin
            found_reg <= hit;
            status_reg <= (cmd_reg == hkms_pkg::CMD_ADD) && !hit && !have_free;
        end
    end

    assign stat = '{clear_done: (clr_reg == BW'(hkms_pkg::BUCKETS - 1)),
                    div_done:   (cnt_reg == DW'(31))};

    always_comb
    begin
        hit_oh = '0;
        free_oh = '0;
        hit = 1'b0;
        have_free = 1'b0;
        for (int w = 0; w < W; w++)
        begin
            if (row_rd[w*33+32])
            begin
                if (!hit && row_rd[w*33 +: 32] == key_reg)
                begin
                    hit = 1'b1;
                    hit_oh[w] = 1'b1;
                end
            end
            else if (!have_free)
            begin
                have_free = 1'b1;
                free_oh[w] = 1'b1;
            end
        end
    end

    always_comb
    begin
        row_wr = row_rd;
        row_we = 1'b0;
        waddr = rem_reg[BW-1:0];
        if (ctrl.clear_step)
        begin
            row_we = 1'b1;
            row_wr = '0;
            waddr = clr_reg;
        end
        else if (ctrl.update)
        begin
            for (int w = 0; w < W; w++)
            begin
                if (cmd_reg == hkms_pkg::CMD_ADD && !hit && free_oh[w])
                begin
                    row_wr[w*33 +: 33] = {1'b1, key_reg};
                    row_we = 1'b1;
                end
                if (cmd_reg == hkms_pkg::CMD_DELETE && hit_oh[w])
                begin
                    row_wr[w*33+32] = 1'b0;
                    row_we = 1'b1;
                end
            end
        end
    end

    hkms_ram #(.WIDTH(hkms_pkg::ROW_W), .DEPTH(hkms_pkg::BUCKETS)) u_ram (
        .clk   (clk),
        .we    (row_we),
        .waddr (waddr),
        .wdata (row_wr),
        .raddr (rem_reg[BW-1:0]),
        .rdata (row_rd)
    );

    assign found = found_reg;
    assign status = status_reg;

`ifndef SYNTHESIS
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.read_row |-> (rem_reg < div_reg)) else $error("remainder out of range");
    a_status_add: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.update |=> (!status_reg || !found_reg)) else $error("full with hit");
    a_hit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.update |-> $onehot0(hit_oh)) else $error("multiple hits");
`endif
endmodule
`default_nettype wire

>>> design/hashed_key_membership_set_core.sv
`default_nettype none
// Set of 32-bit key hashes held in BUCKETS rows of WAYS ways. Each request
// (contains, add, delete; code 3 acts as contains) picks row key_hash modulo
// the configured bucket count (0 acts as 1, above BUCKETS as BUCKETS) and
// returns one response: found, and status 1 only for an add refused by a
// full row. A request occupies the block for the accepting cycle, which
// loads it, 32 steps of a bit-serial remainder unit, a row read, a row
// update, and the response cycle. The next request can be taken in the cycle
// after the response leaves, so a stalled response adds its stall cycles;
// one request is in flight at a time. After reset a clearing pass over
// every row empties the store before the first request is taken.
// Write the bucket count only while idle.
module hashed_key_membership_set_core (
    input  wire logic       clk,
    input  wire logic       rst_n,
    hkms_req_if.sink        req,
    hkms_rsp_if.source      rsp,
    input  wire logic       cfg_we,
    input  wire logic [8:0] cfg_wdata
);
    logic [8:0] nbkt_reg;
    hkms_pkg::ctrl_t ctrl;
    hkms_pkg::stat_t stat;

    // hold the bucket count until rewritten
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nbkt_reg <= 9'd256;
        end
        else if (cfg_we)
        begin
            nbkt_reg <= cfg_wdata;
        end
    end

    hkms_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    hkms_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .stat     (stat),
        .cmd      (req.cmd),
        .key_hash (req.key_hash),
        .nbkt     (nbkt_reg),
        .found    (rsp.found),
        .status   (rsp.status)
    );
endmodule
`default_nettype wire
